// File: hw/rtl/frc_pkg.sv
package frc_pkg;

  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned CRC_BYTES    = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] POS_MAX  = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_SIZE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_SIZE    = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/frc_in_if.sv
interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/frc_out_if.sv
interface frc_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       verdict_valid;
  logic [2:0] status;

  modport source (output valid, output payload_valid, output payload_byte,
                  output verdict_valid, output status, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input verdict_valid, input status, output ready);
endinterface

// File: hw/rtl/framed_record_checker.sv
// framed_record_checker
// checks a stored record streamed one byte per beat on in_ch, with last_byte
// on the final beat of the buffer. record layout: 16-bit le magic, version
// byte, 16-bit le size, payload, 16-bit le crc-16/ccitt-false over header
// and payload. magic, version and payload size are set through the cfg port;
// the user must write them only while the block is idle; the block does not enforce it.
// out_ch carries one beat for every payload byte (payload_valid) and one for
// the last input beat (verdict_valid with status), one beat if the last is a
// payload byte; other input beats give no output beat. status: ok, too short,
// bad magic, bad version, bad size, bad crc, first failing check wins.
// an output beat is presented in the cycle after its input beat is taken; one
// byte is taken every cycle while the receiver does not stall, with a byte-wide
// crc update and the one output register.
// a stalled receiver holds the output register; in_ch.ready stays high while
// that register is empty or being drained, so the stream runs back to back.
// reset (rst_n low, synchronous) clears the config registers to zero, the record
// state to its start and the output register to empty; the last beat of a
// record also returns the record state to its start.
module framed_record_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  frc_in_if.sink                               in_ch,
  frc_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [frc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  logic [15:0] magic_r;
  logic [7:0]  version_r;
  logic [15:0] size_r;

  logic [15:0]      pos_r,   pos_nxt;
  logic [15:0]      crc_r,   crc_nxt;
  frc_pkg::status_t fault_r, fault_nxt;
  logic [7:0]       held_r,  held_nxt;
  logic             match_r, match_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic             opv_r,    opv_nxt;
  logic [7:0]       obyte_r,  obyte_nxt;
  logic             ovv_r,    ovv_nxt;
  frc_pkg::status_t ost_r,    ost_nxt;

  logic        accept;
  logic        active;
  logic [16:0] body_end;
  logic [16:0] total;
  logic [16:0] pos_inc;
  logic [15:0] word;
  logic        in_body;
  logic        emit;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign active   = pos_r != frc_pkg::POS_MAX;
  assign body_end = 17'(frc_pkg::HEADER_BYTES) + {1'b0, size_r};
  assign total    = body_end + 17'(frc_pkg::CRC_BYTES);
  assign pos_inc  = {1'b0, pos_r} + 17'd1;
  assign word     = {in_ch.data_byte, held_r};
  assign in_body  = {1'b0, pos_r} < body_end;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
      size_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        frc_pkg::CFG_MAGIC:   magic_r   <= cfg_wdata;
        frc_pkg::CFG_VERSION: version_r <= cfg_wdata[7:0];
        frc_pkg::CFG_SIZE:    size_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // record state and result
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    fault_nxt  = fault_r;
    held_nxt   = held_r;
    match_nxt  = match_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    opv_nxt    = opv_r;
    obyte_nxt  = obyte_r;
    ovv_nxt    = ovv_r;
    ost_nxt    = ost_r;
    emit       = 1'b0;

    if (accept) begin
      if (active) begin
        case (pos_r)
          16'd0, 16'd3: held_nxt = in_ch.data_byte;
          16'd1: if (word != magic_r && fault_r == frc_pkg::ST_OK)
                   fault_nxt = frc_pkg::ST_MAGIC;
          16'd2: if (in_ch.data_byte != version_r && fault_r == frc_pkg::ST_OK)
                   fault_nxt = frc_pkg::ST_VERSION;
          16'd4: if (word != size_r && fault_r == frc_pkg::ST_OK)
                   fault_nxt = frc_pkg::ST_SIZE;
          default: ;
        endcase
        if (in_body) begin
          crc_nxt = frc_pkg::crc_byte(crc_r, in_ch.data_byte);
        end else if ({1'b0, pos_r} == body_end) begin
          held_nxt = in_ch.data_byte;
        end else if ({1'b0, pos_r} == body_end + 17'd1) begin
          match_nxt = word == crc_r;
        end
        pos_nxt = pos_inc[15:0];
      end

      opv_nxt   = active && in_body && pos_r >= 16'(frc_pkg::HEADER_BYTES);
      obyte_nxt = opv_nxt ? in_ch.data_byte : 8'd0;
      ovv_nxt   = in_ch.last_byte;
      ost_nxt   = frc_pkg::ST_OK;
      if (in_ch.last_byte) begin
        if (total > 17'h0FFFF || pos_inc < total) begin
          ost_nxt = frc_pkg::ST_SHORT;
        end else if (fault_r != frc_pkg::ST_OK) begin
          ost_nxt = fault_r;
        end else if (!match_nxt) begin
          ost_nxt = frc_pkg::ST_CRC;
        end
        // start a new record
        pos_nxt   = '0;
        crc_nxt   = frc_pkg::CRC_INIT;
        fault_nxt = frc_pkg::ST_OK;
        held_nxt  = '0;
        match_nxt = 1'b0;
      end
      emit = opv_nxt || in_ch.last_byte;
      if (emit) begin
        ovalid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= frc_pkg::CRC_INIT;
      fault_r  <= frc_pkg::ST_OK;
      held_r   <= '0;
      match_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      fault_r  <= fault_nxt;
      held_r   <= held_nxt;
      match_r  <= match_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      opv_r   <= opv_nxt;
      obyte_r <= obyte_nxt;
      ovv_r   <= ovv_nxt;
      ost_r   <= ost_nxt;
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.payload_valid = opv_r;
  assign out_ch.payload_byte  = obyte_r;
  assign out_ch.verdict_valid = ovv_r;
  assign out_ch.status        = ost_r;

  // every output beat is a payload byte or a verdict
  a_beat_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (opv_r || ovv_r))
    else $error("output beat with neither payload nor verdict");

  // status is only reported with a verdict
  a_status_needs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !ovv_r) |-> (ost_r == frc_pkg::ST_OK))
    else $error("status set without verdict");

  // the last beat restarts the record
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_byte) |=> (pos_r == '0 && crc_r == frc_pkg::CRC_INIT
                                     && fault_r == frc_pkg::ST_OK))
    else $error("record state not restarted after last beat");

  // saturated position holds until the record ends
  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.last_byte && pos_r == frc_pkg::POS_MAX)
      |=> (pos_r == frc_pkg::POS_MAX))
    else $error("position left saturation");

endmodule

// File: test/framed_record_checker_tb.sv
module framed_record_checker_tb;

  localparam logic [frc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_VERSION,
    REC_BAD_SIZE,
    REC_SIZE_HIGH,
    REC_BAD_CRC,
    REC_TRUNCATED,
    REC_TRAILING,
    REC_MIXED,
    REC_NOISE
  } rec_kind_t;

  typedef struct packed {
    logic             pvalid;
    logic [7:0]       pbyte;
    logic             vvalid;
    frc_pkg::status_t status;
  } out_beat_t;

  class record_tracker;
    logic [15:0]      magic_reg;
    logic [7:0]       version_reg;
    logic [15:0]      size_reg;
    logic [15:0]      pos;
    logic [15:0]      crc;
    frc_pkg::status_t first_fault;
    logic [7:0]       low_hold;
    logic             trailer_ok;
    out_beat_t        awaited_beats[$];
    int               errors;

    function new();
      magic_reg   = '0;
      version_reg = '0;
      size_reg    = '0;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      pos         = '0;
      crc         = frc_pkg::CRC_INIT;
      first_fault = frc_pkg::ST_OK;
      low_hold    = '0;
      trailer_ok  = 1'b0;
    endfunction

    // shifts the byte in one bit at a time, msb first
    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? frc_pkg::CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void write_reg(logic [frc_pkg::CFG_IDX_W-1:0] idx,
                            logic [frc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        frc_pkg::CFG_MAGIC:   magic_reg   = val;
        frc_pkg::CFG_VERSION: version_reg = val[7:0];
        frc_pkg::CFG_SIZE:    size_reg    = val;
        default: ;
      endcase
    endfunction

    function void flag_fault(frc_pkg::status_t code);
      if (first_fault == frc_pkg::ST_OK) first_fault = code;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned idx;
      int unsigned body_end;
      int unsigned total;
      logic        pv;
      out_beat_t   e;
      idx      = pos;
      body_end = frc_pkg::HEADER_BYTES + size_reg;
      total    = body_end + frc_pkg::CRC_BYTES;
      pv       = 1'b0;
      if (pos != frc_pkg::POS_MAX) begin
        case (idx)
          0, 3: low_hold = b;
          1: if ({b, low_hold} != magic_reg) flag_fault(frc_pkg::ST_MAGIC);
          2: if (b != version_reg) flag_fault(frc_pkg::ST_VERSION);
          4: if ({b, low_hold} != size_reg) flag_fault(frc_pkg::ST_SIZE);
          default: ;
        endcase
        if (idx < body_end) begin
          crc = crc16_step(crc, b);
          pv  = (idx >= frc_pkg::HEADER_BYTES);
        end else if (idx == body_end) begin
          low_hold = b;
        end else if (idx == body_end + 1) begin
          trailer_ok = ({b, low_hold} == crc);
        end
        pos = pos + 16'd1;
      end
      if (pv || last) begin
        e.pvalid = pv;
        e.pbyte  = pv ? b : 8'h00;
        e.vvalid = last;
        if (!last) e.status = frc_pkg::ST_OK;
        else if (total > frc_pkg::POS_MAX || idx + 1 < total) e.status = frc_pkg::ST_SHORT;
        else if (first_fault != frc_pkg::ST_OK) e.status = first_fault;
        else if (!trailer_ok) e.status = frc_pkg::ST_CRC;
        else e.status = frc_pkg::ST_OK;
        awaited_beats.push_back(e);
      end
      if (last) restart();
    endfunction

    function void match_beat(out_beat_t got);
      out_beat_t want;
      if (awaited_beats.size() == 0) begin
        $error("output beat with nothing outstanding");
        errors++;
      end else begin
        want = awaited_beats.pop_front();
        if (got.pvalid !== want.pvalid) begin
          $error("payload_valid: expected %0d, got %0d", want.pvalid, got.pvalid);
          errors++;
        end
        if (got.pbyte !== want.pbyte) begin
          $error("payload_byte: expected %0h, got %0h", want.pbyte, got.pbyte);
          errors++;
        end
        if (got.vvalid !== want.vvalid) begin
          $error("verdict_valid: expected %0d, got %0d", want.vvalid, got.vvalid);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [frc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [frc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  frc_in_if  in_ch();
  frc_out_if out_ch();

  record_tracker tracker;
  out_beat_t     seen;
  int            send_idle = 34;
  int            recv_idle = 52;
  logic          long_hold;
  int            hold_count = 0;
  int            quiet_cycles = 0;
  int unsigned   bytes_sent = 0;

  framed_record_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.take_byte(in_ch.data_byte, in_ch.last_byte);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.pvalid = out_ch.payload_valid;
      seen.pbyte  = out_ch.payload_byte;
      seen.vvalid = out_ch.verdict_valid;
      seen.status = frc_pkg::status_t'(out_ch.status);
      tracker.match_beat(seen);
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] magic, logic [7:0] version, logic [15:0] size);
    logic [15:0] ver_word;
    logic [15:0] spare;
    ver_word = {8'($urandom), version};
    spare    = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= frc_pkg::CFG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    tracker.write_reg(frc_pkg::CFG_MAGIC, magic);
    cfg_index <= frc_pkg::CFG_VERSION;
    cfg_wdata <= ver_word;
    @(posedge clk);
    tracker.write_reg(frc_pkg::CFG_VERSION, ver_word);
    cfg_index <= frc_pkg::CFG_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    tracker.write_reg(frc_pkg::CFG_SIZE, size);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= spare;
    @(posedge clk);
    tracker.write_reg(CFG_SPARE, spare);
    cfg_we <= 1'b0;
  endtask

  task automatic send_record(rec_kind_t kind, int unsigned trail);
    logic [7:0]  rec[$];
    logic [15:0] crc;
    int unsigned pick;
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(12, 1)) rec.push_back(8'($urandom));
    end else begin
      rec.push_back(tracker.magic_reg[7:0]);
      rec.push_back(tracker.magic_reg[15:8]);
      rec.push_back(tracker.version_reg);
      rec.push_back(tracker.size_reg[7:0]);
      rec.push_back(tracker.size_reg[15:8]);
      repeat (tracker.size_reg) rec.push_back(8'($urandom));
      case (kind)
        REC_BAD_MAGIC: begin
          pick = $urandom_range(1);
          rec[pick] ^= 8'(1 << $urandom_range(7));
        end
        REC_BAD_VERSION: rec[2] ^= 8'(1 << $urandom_range(7));
        REC_BAD_SIZE: begin
          pick = 3 + $urandom_range(1);
          rec[pick] ^= 8'(1 << $urandom_range(7));
        end
        REC_SIZE_HIGH: rec[4] ^= 8'(1 << $urandom_range(7));
        REC_MIXED: begin
          for (int i = 0; i < frc_pkg::HEADER_BYTES; i++) begin
            if ($urandom_range(1)) rec[i] ^= 8'(1 << $urandom_range(7));
          end
        end
        default: ;
      endcase
      crc = frc_pkg::CRC_INIT;
      foreach (rec[i]) crc = record_tracker::crc16_step(crc, rec[i]);
      rec.push_back(crc[7:0]);
      rec.push_back(crc[15:8]);
      if (kind == REC_BAD_CRC || (kind == REC_MIXED && $urandom_range(1))) begin
        pick = $urandom_range(rec.size() - 1, frc_pkg::HEADER_BYTES);
        rec[pick] ^= 8'(1 << $urandom_range(7));
      end
      if (kind == REC_TRUNCATED) begin
        pick = $urandom_range(rec.size() - 1, 1);
        while (rec.size() > pick) void'(rec.pop_back());
      end
      if (kind == REC_TRAILING) begin
        repeat (trail) rec.push_back(8'($urandom));
      end
    end
    foreach (rec[i]) push_byte(rec[i], i == rec.size() - 1);
  endtask

  task automatic random_phase(int unsigned goal);
    int unsigned start;
    int unsigned roll;
    int unsigned n;
    rec_kind_t   kind;
    start = bytes_sent;
    n     = 0;
    while (bytes_sent - start < goal) begin
      if (n % 10 == 0) begin
        roll = $urandom_range(99);
        settle();
        write_regs(16'($urandom), 8'($urandom),
                   (roll < 70) ? 16'($urandom_range(16)) :
                   (roll < 95) ? 16'($urandom_range(64, 17)) :
                                 16'($urandom_range(300, 65)));
      end
      roll = $urandom_range(99);
      if (roll < 50) kind = REC_GOOD;
      else if (roll < 56) kind = REC_BAD_MAGIC;
      else if (roll < 62) kind = REC_BAD_VERSION;
      else if (roll < 68) kind = REC_BAD_SIZE;
      else if (roll < 78) kind = REC_BAD_CRC;
      else if (roll < 88) kind = REC_TRUNCATED;
      else if (roll < 94) kind = REC_TRAILING;
      else if (roll < 97) kind = REC_MIXED;
      else kind = REC_NOISE;
      send_record(kind, $urandom_range(4, 1));
      n++;
    end
  endtask

  initial begin
    tracker = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= frc_pkg::CFG_MAGIC;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    long_hold       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at their reset values
    send_record(REC_GOOD, 0);
    send_record(REC_NOISE, 0);
    settle();
    write_regs(16'hFFFF, 8'hFF, 16'd1);
    send_record(REC_GOOD, 0);
    send_record(REC_BAD_MAGIC, 0);
    send_record(REC_BAD_VERSION, 0);
    send_record(REC_SIZE_HIGH, 0);
    send_record(REC_BAD_CRC, 0);
    send_record(REC_TRUNCATED, 0);
    send_record(REC_TRAILING, 2);
    send_record(REC_MIXED, 0);
    // payload size too large for any record to complete
    settle();
    write_regs(16'($urandom), 8'h00, 16'hFFFF);
    send_record(REC_NOISE, 0);

    random_phase(400);
    send_idle = 52;
    recv_idle = 34;
    random_phase(400);
    send_idle = 0;
    recv_idle = 0;

    settle();
    write_regs(16'($urandom), 8'($urandom), 16'd60);
    long_hold <= 1'b1;
    send_record(REC_GOOD, 0);
    send_record(REC_GOOD, 0);
    random_phase(400);

    settle();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
